/* rtl/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned THRESH_W = 16;
	localparam int unsigned CODE_W   = 2;
	localparam int unsigned REG_IDX_W = 2;

	typedef logic [TIME_W-1:0]   time_ms_t;
	typedef logic [THRESH_W-1:0] thresh_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} ev_code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACTIVE_LOW   = 2'd0,
		REG_DEBOUNCE     = 2'd1,
		REG_LONG_PRESS   = 2'd2,
		REG_DOUBLE_CLICK = 2'd3
	} reg_idx_t;

	localparam logic    RST_ACTIVE_LOW   = 1'b1;
	localparam thresh_t RST_DEBOUNCE     = 16'd50;
	localparam thresh_t RST_LONG_PRESS   = 16'd1000;
	localparam thresh_t RST_DOUBLE_CLICK = 16'd400;

	localparam logic [1:0] CLICKS_FOR_DOUBLE = 2'd2;
	localparam logic [1:0] TALLY_MAX         = 2'd3;

	typedef struct packed {
		logic     raw_level;
		time_ms_t now_ms;
	} sample_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic              debounced_level;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] reg_index;
		thresh_t              wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic    active_low;
		thresh_t debounce_time;
		thresh_t long_press_time;
		thresh_t double_click_window;
	} cfg_t;

endpackage

/* rtl/bcc_stream_if.sv */
// ----------------------------------------------------------------------------
// bcc_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface bcc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/button_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_click_classifier
// debounced button input sorted into short, double and long events
// ----------------------------------------------------------------------------
// One poll (raw pin level and a wrapping ms timestamp) enters per transfer on
// sample, and exactly one result (event code, debounced level) leaves on
// result, in order. A poll is taken every cycle when result is not stalled;
// it is held in an input register, is classified in a single pass of
// compare/subtract logic that also updates the button state, and lands in the
// result register, so the rate is one poll per cycle while result is not
// stalled. Registers on cfg: 0 active_low, 1 debounce_time, 2 long_press_time,
// 3 double_click_window; write them only while no poll is in flight.
module button_click_classifier #(
	parameter logic             RstActiveLow   = bcc_pkg::RST_ACTIVE_LOW,
	parameter bcc_pkg::thresh_t RstDebounce    = bcc_pkg::RST_DEBOUNCE,
	parameter bcc_pkg::thresh_t RstLongPress   = bcc_pkg::RST_LONG_PRESS,
	parameter bcc_pkg::thresh_t RstDoubleClick = bcc_pkg::RST_DOUBLE_CLICK
) (
	input  logic         clk,
	input  logic         arst_n,
	bcc_stream_if.sink   sample,
	bcc_stream_if.source result,
	bcc_stream_if.sink   cfg
);

	bcc_pkg::cfg_t     cfg_q;
	bcc_pkg::cfg_wr_t  wr;
	bcc_pkg::sample_t  smp_s1;
	logic              valid_s1;
	logic              out_valid_q;
	bcc_pkg::result_t  out_q;
	logic              advance;
	bcc_pkg::ev_code_t ev;
	logic              stable_level;

	assign wr        = cfg.payload;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low          <= RstActiveLow;
			cfg_q.debounce_time       <= RstDebounce;
			cfg_q.long_press_time     <= RstLongPress;
			cfg_q.double_click_window <= RstDoubleClick;
		end else if (cfg.valid) begin
			unique case (bcc_pkg::reg_idx_t'(wr.reg_index))
				bcc_pkg::REG_ACTIVE_LOW:   cfg_q.active_low          <= wr.wdata[0];
				bcc_pkg::REG_DEBOUNCE:     cfg_q.debounce_time       <= wr.wdata;
				bcc_pkg::REG_LONG_PRESS:   cfg_q.long_press_time     <= wr.wdata;
				bcc_pkg::REG_DOUBLE_CLICK: cfg_q.double_click_window <= wr.wdata;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being emptied
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid)
			smp_s1 <= sample.payload;
	end

	bcc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.smp          (smp_s1),
		.cfg          (cfg_q),
		.ev           (ev),
		.stable_level (stable_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.event_code      <= ev;
			out_q.debounced_level <= stable_level;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

/* rtl/bcc_core.sv */
// ----------------------------------------------------------------------------
// bcc_core
// debounce and click classification state, one poll per step
// ----------------------------------------------------------------------------
module bcc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  bcc_pkg::sample_t       smp,
	input  bcc_pkg::cfg_t          cfg,
	output bcc_pkg::ev_code_t      ev,
	output logic                   stable_level
);

	logic              last_sample_q, stable_q, is_pressed_q, long_done_q, awaiting_q;
	logic [1:0]        tally_q;
	bcc_pkg::time_ms_t db_start_q, press_start_q, win_start_q;

	logic              last_sample_d, stable_d, is_pressed_d, long_done_d, awaiting_d;
	logic [1:0]        tally_d;
	bcc_pkg::time_ms_t db_start_d, press_start_d, win_start_d;
	bcc_pkg::ev_code_t ev_d;
	logic              lvl;
	bcc_pkg::time_ms_t db_elapsed, press_elapsed, win_elapsed;

	always_comb begin
		lvl           = smp.raw_level ^ cfg.active_low;
		last_sample_d = lvl;
		db_start_d    = (lvl != last_sample_q) ? smp.now_ms : db_start_q;
		stable_d      = stable_q;
		press_start_d = press_start_q;
		is_pressed_d  = is_pressed_q;
		long_done_d   = long_done_q;
		tally_d       = tally_q;
		awaiting_d    = awaiting_q;
		win_start_d   = win_start_q;
		ev_d          = bcc_pkg::EV_NONE;

		db_elapsed = smp.now_ms - db_start_d;
		if (db_elapsed >= {16'd0, cfg.debounce_time} && lvl != stable_q) begin
			stable_d = lvl;
			if (lvl) begin
				press_start_d = smp.now_ms;
				is_pressed_d  = 1'b1;
				long_done_d   = 1'b0;
			end else begin
				if (is_pressed_q && !long_done_q) begin
					if (tally_q < bcc_pkg::TALLY_MAX)
						tally_d = tally_q + 2'd1;
					if (tally_d == 2'd1) begin
						awaiting_d  = 1'b1;
						win_start_d = smp.now_ms;
					end else if (tally_d >= bcc_pkg::CLICKS_FOR_DOUBLE) begin
						awaiting_d = 1'b0;
						tally_d    = 2'd0;
						ev_d       = bcc_pkg::EV_DOUBLE;
					end
				end
				is_pressed_d = 1'b0;
			end
		end

		press_elapsed = smp.now_ms - press_start_d;
		if (is_pressed_d && !long_done_d &&
		    press_elapsed >= {16'd0, cfg.long_press_time}) begin
			long_done_d = 1'b1;
			awaiting_d  = 1'b0;
			tally_d     = 2'd0;
			if (ev_d == bcc_pkg::EV_NONE)
				ev_d = bcc_pkg::EV_LONG;
		end

		win_elapsed = smp.now_ms - win_start_d;
		if (awaiting_d && !is_pressed_d &&
		    win_elapsed >= {16'd0, cfg.double_click_window}) begin
			awaiting_d = 1'b0;
			tally_d    = 2'd0;
			if (ev_d == bcc_pkg::EV_NONE)
				ev_d = bcc_pkg::EV_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= 1'b0;
			stable_q      <= 1'b0;
			db_start_q    <= '0;
			press_start_q <= '0;
			is_pressed_q  <= 1'b0;
			long_done_q   <= 1'b0;
			tally_q       <= 2'd0;
			awaiting_q    <= 1'b0;
			win_start_q   <= '0;
		end else if (step) begin
			last_sample_q <= last_sample_d;
			stable_q      <= stable_d;
			db_start_q    <= db_start_d;
			press_start_q <= press_start_d;
			is_pressed_q  <= is_pressed_d;
			long_done_q   <= long_done_d;
			tally_q       <= tally_d;
			awaiting_q    <= awaiting_d;
			win_start_q   <= win_start_d;
		end
	end

	assign ev           = ev_d;
	assign stable_level = stable_d;

endmodule

/* rtl/bcc_checker.sv */
// ----------------------------------------------------------------------------
// bcc_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
module bcc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bcc_pkg::CODE_W-1:0]   event_code,
	input logic                         debounced_level
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code) &&
		$stable(debounced_level))
		else $error("stalled result changed");

	// long press only while the button is held
	a_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == bcc_pkg::EV_LONG |-> debounced_level)
		else $error("long press reported while released");

	// double click completes on a release
	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == bcc_pkg::EV_DOUBLE |-> !debounced_level)
		else $error("double click reported while pressed");

	// short click fires only after release
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == bcc_pkg::EV_SHORT |-> !debounced_level)
		else $error("short click reported while pressed");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.event_code      (result.payload.event_code),
	.debounced_level (result.payload.debounced_level)
);

/* tb/button_click_classifier_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// self-checking bench for the button click classifier
// ----------------------------------------------------------------------------
// Polls go in on the sample channel and each result coming out is compared
// with a prediction kept in the bench (debounce, click tally, double-click
// window, long press). A short directed table covers the threshold edges,
// every event code, release after long press, glitches, zero and full-range
// thresholds and timestamp wrap. Then random button sessions run under
// changing register settings and several patterns of source idling and sink
// back-pressure.
// ----------------------------------------------------------------------------
module button_click_classifier_tb;

	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASES       = 8;
	localparam int PHASE_POLLS  = 125;

	typedef struct {
		bit                 is_cfg;
		logic               raw;
		bcc_pkg::time_ms_t  t_ms;
		bcc_pkg::reg_idx_t  idx;
		bcc_pkg::thresh_t   wdata;
		bit                 typed;
		bcc_pkg::result_t   want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	bcc_stream_if #(.payload_t(bcc_pkg::sample_t)) sample_ch ();
	bcc_stream_if #(.payload_t(bcc_pkg::result_t)) result_ch ();
	bcc_stream_if #(.payload_t(bcc_pkg::cfg_wr_t)) cfg_ch ();

	button_click_classifier DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// register copy and button state of the predictor
	bcc_pkg::cfg_t     cur_cfg = '{bcc_pkg::RST_ACTIVE_LOW, bcc_pkg::RST_DEBOUNCE,
		bcc_pkg::RST_LONG_PRESS, bcc_pkg::RST_DOUBLE_CLICK};
	logic              pin_last     = 1'b0;
	logic              level_stable = 1'b0;
	bcc_pkg::time_ms_t bounce_t0    = '0;
	bcc_pkg::time_ms_t press_t0     = '0;
	logic              held         = 1'b0;
	logic              long_fired   = 1'b0;
	logic [1:0]        clicks       = 2'd0;
	logic              window_open  = 1'b0;
	bcc_pkg::time_ms_t window_t0    = '0;

	bcc_pkg::result_t  pending_results[$];
	dir_row_t          dir_tab[$];
	int                error_count   = 0;
	int                quiet_cycles  = 0;
	int                src_idle_pct  = 0;
	int                snk_stall_pct = 0;
	bcc_pkg::time_ms_t t_now         = '0;
	logic              want_pressed  = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bcc_pkg::time_ms_t elapsed(input bcc_pkg::time_ms_t t_ms,
			input bcc_pkg::time_ms_t t0);
		bcc_pkg::time_ms_t d;
		d = t_ms - t0;
		return d;
	endfunction

	function automatic bcc_pkg::result_t classify_poll(input bcc_pkg::sample_t s);
		logic              lvl;
		bcc_pkg::ev_code_t ev;
		bcc_pkg::result_t  r;
		lvl = s.raw_level ^ cur_cfg.active_low;
		ev = bcc_pkg::EV_NONE;
		if (lvl != pin_last) begin
			pin_last = lvl;
			bounce_t0 = s.now_ms;
		end
		if (elapsed(s.now_ms, bounce_t0) >=
				bcc_pkg::time_ms_t'(cur_cfg.debounce_time) &&
				lvl != level_stable) begin
			level_stable = lvl;
			if (level_stable) begin
				press_t0 = s.now_ms;
				held = 1'b1;
				long_fired = 1'b0;
			end else begin
				if (held && !long_fired) begin
					if (clicks < bcc_pkg::TALLY_MAX)
						clicks = clicks + 2'd1;
					if (clicks == 2'd1) begin
						window_open = 1'b1;
						window_t0 = s.now_ms;
					end else if (clicks >= bcc_pkg::CLICKS_FOR_DOUBLE) begin
						window_open = 1'b0;
						clicks = 2'd0;
						ev = bcc_pkg::EV_DOUBLE;
					end
				end
				held = 1'b0;
			end
		end
		if (held && !long_fired &&
				elapsed(s.now_ms, press_t0) >=
				bcc_pkg::time_ms_t'(cur_cfg.long_press_time)) begin
			long_fired = 1'b1;
			window_open = 1'b0;
			clicks = 2'd0;
			if (ev == bcc_pkg::EV_NONE)
				ev = bcc_pkg::EV_LONG;
		end
		if (window_open && !held &&
				elapsed(s.now_ms, window_t0) >=
				bcc_pkg::time_ms_t'(cur_cfg.double_click_window)) begin
			window_open = 1'b0;
			clicks = 2'd0;
			if (ev == bcc_pkg::EV_NONE)
				ev = bcc_pkg::EV_SHORT;
		end
		r.event_code = ev;
		r.debounced_level = level_stable;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// sink side: random back-pressure
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		bcc_pkg::result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no poll waiting, event_code",
					int'(result_ch.payload.event_code), -1);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.payload.event_code !== want.event_code)
					report_mismatch("event_code", int'(result_ch.payload.event_code),
						int'(want.event_code));
				if (result_ch.payload.debounced_level !== want.debounced_level)
					report_mismatch("debounced_level",
						int'(result_ch.payload.debounced_level),
						int'(want.debounced_level));
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	task automatic send_poll(input bcc_pkg::sample_t s, input bit typed,
			input bcc_pkg::result_t want);
		bcc_pkg::result_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.payload <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		r = classify_poll(s);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic write_reg(input bcc_pkg::reg_idx_t idx, input bcc_pkg::thresh_t val);
		bcc_pkg::cfg_wr_t w;
		w.reg_index = idx;
		w.wdata = val;
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= w;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			bcc_pkg::REG_ACTIVE_LOW:   cur_cfg.active_low = val[0];
			bcc_pkg::REG_DEBOUNCE:     cur_cfg.debounce_time = val;
			bcc_pkg::REG_LONG_PRESS:   cur_cfg.long_press_time = val;
			bcc_pkg::REG_DOUBLE_CLICK: cur_cfg.double_click_window = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic dir_row_t poll_row(input logic raw, input bcc_pkg::time_ms_t t_ms);
		dir_row_t d;
		d.is_cfg = 1'b0;
		d.raw = raw;
		d.t_ms = t_ms;
		d.idx = bcc_pkg::REG_ACTIVE_LOW;
		d.wdata = '0;
		d.typed = 1'b0;
		d.want = '0;
		return d;
	endfunction

	function automatic dir_row_t poll_exp(input logic raw, input bcc_pkg::time_ms_t t_ms,
			input bcc_pkg::ev_code_t ev, input logic lvl);
		dir_row_t d;
		d = poll_row(raw, t_ms);
		d.typed = 1'b1;
		d.want.event_code = ev;
		d.want.debounced_level = lvl;
		return d;
	endfunction

	function automatic dir_row_t cfg_row(input bcc_pkg::reg_idx_t idx,
			input bcc_pkg::thresh_t val);
		dir_row_t d;
		d = poll_row(1'b0, '0);
		d.is_cfg = 1'b1;
		d.idx = idx;
		d.wdata = val;
		return d;
	endfunction

	// random button sessions: hold a level for a random time, with glitches
	// and the odd jump of the timestamp
	task automatic run_phase(input int n_polls, input bit pause_midway);
		int                sent;
		int                step_max;
		int unsigned       hold;
		bcc_pkg::time_ms_t seg_t0;
		bcc_pkg::sample_t  s;
		logic              lvl;
		sent = 0;
		step_max = (int'(cur_cfg.debounce_time) + int'(cur_cfg.long_press_time) +
			int'(cur_cfg.double_click_window)) / 16 + 2;
		while (sent < n_polls) begin
			want_pressed = !want_pressed;
			hold = $urandom_range(0, step_max * 16 + 8);
			seg_t0 = t_now;
			do begin
				lvl = want_pressed;
				if ($urandom_range(0, 19) == 0)
					lvl = !lvl;
				s.raw_level = lvl ^ cur_cfg.active_low;
				s.now_ms = t_now;
				send_poll(s, 1'b0, '0);
				sent++;
				if (pause_midway && sent == n_polls / 2)
					wait_drained();
				if ($urandom_range(0, 99) == 0)
					t_now = $urandom();
				else
					t_now = t_now + bcc_pkg::time_ms_t'($urandom_range(0, step_max));
			end while (sent < n_polls && elapsed(t_now, seg_t0) < hold);
		end
	endtask

	initial begin
		bcc_pkg::sample_t s;
		bcc_pkg::cfg_t    rc;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		result_ch.ready = 1'b0;

		// reset settings: active low, debounce 50, long 1000, window 400
		dir_tab.push_back(poll_exp(1'b1, 32'd0, bcc_pkg::EV_NONE, 1'b0));
		dir_tab.push_back(poll_row(1'b0, 32'd10));
		dir_tab.push_back(poll_exp(1'b0, 32'd60, bcc_pkg::EV_NONE, 1'b1));
		dir_tab.push_back(poll_row(1'b1, 32'd100));
		dir_tab.push_back(poll_row(1'b1, 32'd150));
		dir_tab.push_back(poll_row(1'b1, 32'd549));
		dir_tab.push_back(poll_exp(1'b1, 32'd550, bcc_pkg::EV_SHORT, 1'b0));
		// two clicks inside the window
		dir_tab.push_back(poll_row(1'b0, 32'd600));
		dir_tab.push_back(poll_row(1'b0, 32'd650));
		dir_tab.push_back(poll_row(1'b1, 32'd700));
		dir_tab.push_back(poll_row(1'b1, 32'd750));
		dir_tab.push_back(poll_row(1'b0, 32'd800));
		dir_tab.push_back(poll_row(1'b0, 32'd850));
		dir_tab.push_back(poll_row(1'b1, 32'd900));
		dir_tab.push_back(poll_exp(1'b1, 32'd950, bcc_pkg::EV_DOUBLE, 1'b0));
		// long press, then a release that is no click
		dir_tab.push_back(poll_row(1'b0, 32'd1000));
		dir_tab.push_back(poll_row(1'b0, 32'd1050));
		dir_tab.push_back(poll_exp(1'b0, 32'd2050, bcc_pkg::EV_LONG, 1'b1));
		dir_tab.push_back(poll_row(1'b1, 32'd2060));
		dir_tab.push_back(poll_exp(1'b1, 32'd2110, bcc_pkg::EV_NONE, 1'b0));
		// glitch shorter than the debounce time
		dir_tab.push_back(poll_row(1'b0, 32'd2200));
		dir_tab.push_back(poll_row(1'b1, 32'd2210));
		dir_tab.push_back(poll_row(1'b1, 32'd2300));
		// zero thresholds, active high, timestamp wrap
		dir_tab.push_back(cfg_row(bcc_pkg::REG_DEBOUNCE, 16'd0));
		dir_tab.push_back(cfg_row(bcc_pkg::REG_LONG_PRESS, 16'd0));
		dir_tab.push_back(cfg_row(bcc_pkg::REG_DOUBLE_CLICK, 16'd0));
		dir_tab.push_back(cfg_row(bcc_pkg::REG_ACTIVE_LOW, 16'd0));
		dir_tab.push_back(poll_row(1'b1, 32'hFFFF_FFF0));
		dir_tab.push_back(poll_row(1'b0, 32'h0000_0005));
		dir_tab.push_back(cfg_row(bcc_pkg::REG_LONG_PRESS, 16'hFFFF));
		dir_tab.push_back(poll_row(1'b1, 32'h0000_0010));
		dir_tab.push_back(poll_row(1'b0, 32'h0000_0020));
		// full-range thresholds
		dir_tab.push_back(cfg_row(bcc_pkg::REG_DEBOUNCE, 16'hFFFF));
		dir_tab.push_back(cfg_row(bcc_pkg::REG_DOUBLE_CLICK, 16'hFFFF));
		dir_tab.push_back(poll_row(1'b1, 32'hFFFF_0000));
		dir_tab.push_back(poll_row(1'b1, 32'hFFFF_FFFF));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_drained();
				write_reg(dir_tab[i].idx, dir_tab[i].wdata);
				cfg_ch.valid <= 1'b0;
			end else begin
				s.raw_level = dir_tab[i].raw;
				s.now_ms = dir_tab[i].t_ms;
				send_poll(s, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 45;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 45;
				end
				default: begin
					src_idle_pct = 17;
					snk_stall_pct = 17;
				end
			endcase
			wait_drained();
			rc.active_low = $urandom_range(0, 1);
			rc.debounce_time = $urandom_range(0, 30);
			rc.long_press_time = $urandom_range(0, 400);
			rc.double_click_window = $urandom_range(0, 250);
			case ($urandom_range(0, 7))
				0: rc.debounce_time = '0;
				1: rc.long_press_time = '1;
				2: rc.double_click_window = '0;
				3: rc.double_click_window = '1;
				4: rc.long_press_time = '0;
				default: ;
			endcase
			write_reg(bcc_pkg::REG_ACTIVE_LOW, bcc_pkg::thresh_t'(rc.active_low));
			write_reg(bcc_pkg::REG_DEBOUNCE, rc.debounce_time);
			write_reg(bcc_pkg::REG_LONG_PRESS, rc.long_press_time);
			write_reg(bcc_pkg::REG_DOUBLE_CLICK, rc.double_click_window);
			cfg_ch.valid <= 1'b0;
			run_phase(PHASE_POLLS, p == 0);
		end

		wait_drained();
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
